// File: sv/jsc_pkg.sv
// Shared types and constants for the JSON object structure checker.
`default_nettype none

package jsc_pkg;

  localparam int MAX_NESTING_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CHAR_TAB     = 16'h0009;
  localparam logic [15:0] CHAR_CR      = 16'h000D;
  localparam logic [15:0] CHAR_SPACE   = 16'h0020;
  localparam logic [15:0] CHAR_BOM     = 16'hFEFF;
  localparam logic [15:0] CHAR_LBRACE  = 16'h007B;
  localparam logic [15:0] CHAR_RBRACE  = 16'h007D;
  localparam logic [15:0] CHAR_LBRACK  = 16'h005B;
  localparam logic [15:0] CHAR_RBRACK  = 16'h005D;
  localparam logic [15:0] CHAR_QUOTE   = 16'h0022;
  localparam logic [15:0] CHAR_BSLASH  = 16'h005C;

  // Stack entry kinds
  localparam logic KIND_BRACE = 1'b0;
  localparam logic KIND_BRACK = 1'b1;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        last;
  } jsc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jsc_qstat_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_BODY,
    PH_STR,
    PH_ESC,
    PH_TAIL,
    PH_FAIL
  } scan_phase_t;

  typedef enum logic [1:0] {
    VERDICT_VALID     = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_TOO_DEEP  = 2'd2
  } verdict_t;

endpackage

`default_nettype wire

// File: sv/json_object_structure_check.sv
// Top level of the JSON object structure checker.
`default_nettype none

// Checks that a stream of UTF-16 code units, one per request on the char
// channel, forms one JSON object. Leading ASCII whitespace and byte order
// marks are skipped, the first other unit must be an opening brace, braces
// and brackets must nest and match, string contents and escapes are
// skipped, and after the outer close only whitespace or byte order marks
// may follow. The request flagged by last_char produces one verdict request:
// 0 valid, 1 malformed, 2 nesting deeper than MAX_NESTING. Other characters
// produce nothing. The block takes one character per cycle, sustained,
// including across text boundaries, while the verdict output is not
// stalled; the next text may follow the last character of the previous one
// directly. With the queue otherwise empty, a last character is written
// into the four-entry queue when it is accepted, and the scan engine, which
// updates its nesting stack memory at most once per cycle, then takes it
// into the verdict register. A stalled verdict holds and the front keeps
// filling the queue until it is full. The stack memory needs no clearing
// after reset.
module json_object_structure_check #(
  parameter int MAX_NESTING = jsc_pkg::MAX_NESTING_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [15:0] char_code,
  input  wire logic        last_char,
  output logic             verdict_valid,
  input  wire logic        verdict_stall,
  output logic [1:0]       verdict
);
  import jsc_pkg::*;

  logic       q_push;
  jsc_item_t  q_push_item;
  logic       q_pop;
  jsc_item_t  q_head;
  jsc_qstat_t q_stat;

  // classify and enqueue
  jsc_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .qstat      (q_stat),
    .push       (q_push),
    .push_item  (q_push_item)
  );

  // decouple the front from a stalled verdict
  jsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .qstat     (q_stat)
  );

  // advance the scan and produce the verdict
  jsc_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .qstat         (q_stat),
    .pop           (q_pop),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

  // the engine never drains an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("scan engine popped an empty queue");

  // a request written without a read leaves the queue occupied
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("queue lost a pushed request");

  // a new verdict only follows a consumed last character
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(q_pop && q_head.last))
    else $error("verdict raised without a last character");

endmodule

`default_nettype wire

// File: sv/jsc_front.sv
// Front end: accepts characters and classifies them into queue requests.
`default_nettype none

module jsc_front (
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire logic [15:0]       char_code,
  input  wire logic              last_char,
  input  wire jsc_pkg::jsc_qstat_t qstat,
  output logic                   push,
  output jsc_pkg::jsc_item_t     push_item
);
  import jsc_pkg::*;

  char_class_t cls;

  always_comb begin
    if (char_code inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE, CHAR_BOM}) begin
      cls = CLS_BLANK;
    end else begin
      case (char_code)
        CHAR_LBRACE: cls = CLS_LBRACE;
        CHAR_RBRACE: cls = CLS_RBRACE;
        CHAR_LBRACK: cls = CLS_LBRACK;
        CHAR_RBRACK: cls = CLS_RBRACK;
        CHAR_QUOTE:  cls = CLS_QUOTE;
        CHAR_BSLASH: cls = CLS_BSLASH;
        default:     cls = CLS_OTHER;
      endcase
    end
  end

  // hold the source off while the queue has no room
  assign char_stall     = qstat.full;
  assign push           = char_valid && !qstat.full;
  assign push_item.cls  = cls;
  assign push_item.last = last_char;

endmodule

`default_nettype wire

// File: sv/jsc_queue.sv
// Short request queue between the front end and the scan engine.
`default_nettype none

module jsc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire jsc_pkg::jsc_item_t push_item,
  input  wire logic               pop,
  output jsc_pkg::jsc_item_t      head,
  output jsc_pkg::jsc_qstat_t     qstat
);
  import jsc_pkg::*;

  jsc_item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

endmodule

`default_nettype wire

// File: sv/jsc_back.sv
// Scan engine: phase machine, nesting stack and verdict register.
`default_nettype none

module jsc_back #(
  parameter int MAX_NESTING = jsc_pkg::MAX_NESTING_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire jsc_pkg::jsc_item_t  head,
  input  wire jsc_pkg::jsc_qstat_t qstat,
  output logic                     pop,
  output logic                     verdict_valid,
  input  wire logic                verdict_stall,
  output logic [1:0]               verdict
);
  import jsc_pkg::*;

  localparam int AW = $clog2(MAX_NESTING);
  localparam int DW = $clog2(MAX_NESTING + 1);

  logic            stack_mem [MAX_NESTING];
  logic            top_kind;

  scan_phase_t     phase, phase_next;
  logic [DW-1:0]   depth, depth_next;
  logic            overflow, overflow_next;
  logic            push_en;
  logic            push_kind;
  logic [DW-1:0]   depth_eff;
  logic [DW-1:0]   rd_tmp;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  verdict_t        verdict_value;

  // take an item unless its verdict would land on a full, stalled output
  assign pop = !qstat.empty && (!head.last || !verdict_valid || !verdict_stall);

  // next state
  always_comb begin
    phase_next    = phase;
    depth_next    = depth;
    overflow_next = overflow;
    push_en       = 1'b0;
    push_kind     = KIND_BRACE;
    case (phase)
      PH_LEAD: begin
        if (head.cls == CLS_LBRACE) begin
          push_en = 1'b1;
        end else if (head.cls != CLS_BLANK) begin
          phase_next = PH_FAIL;
        end
      end
      PH_BODY: begin
        case (head.cls)
          CLS_QUOTE:  phase_next = PH_STR;
          CLS_LBRACE: push_en = 1'b1;
          CLS_LBRACK: begin
            push_en   = 1'b1;
            push_kind = KIND_BRACK;
          end
          CLS_RBRACE, CLS_RBRACK: begin
            if (depth == '0 ||
                top_kind != ((head.cls == CLS_RBRACK) ? KIND_BRACK : KIND_BRACE)) begin
              phase_next = PH_FAIL;
            end else begin
              depth_next = depth - 1'b1;
              if (depth_next == '0) phase_next = PH_TAIL;
            end
          end
          default: phase_next = phase;
        endcase
      end
      PH_STR: begin
        if (head.cls == CLS_BSLASH) phase_next = PH_ESC;
        else if (head.cls == CLS_QUOTE) phase_next = PH_BODY;
      end
      PH_ESC: phase_next = PH_STR;
      PH_TAIL: begin
        if (head.cls != CLS_BLANK) phase_next = PH_FAIL;
      end
      default: phase_next = PH_FAIL;
    endcase
    // opening past the stack limit stops the scan
    if (push_en) begin
      if (depth == DW'(MAX_NESTING)) begin
        push_en       = 1'b0;
        overflow_next = 1'b1;
        phase_next    = PH_FAIL;
      end else begin
        depth_next = depth + 1'b1;
        phase_next = PH_BODY;
      end
    end
  end

  // outputs
  always_comb begin
    if (overflow_next) verdict_value = VERDICT_TOO_DEEP;
    else if (phase_next == PH_TAIL) verdict_value = VERDICT_VALID;
    else verdict_value = VERDICT_MALFORMED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      depth    <= '0;
      overflow <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        phase    <= PH_LEAD;
        depth    <= '0;
        overflow <= 1'b0;
      end else begin
        phase    <= phase_next;
        depth    <= depth_next;
        overflow <= overflow_next;
      end
    end
  end

  // stack memory; the read port tracks the top entry at the next depth
  always_comb begin
    if (!pop) depth_eff = depth;
    else if (head.last) depth_eff = '0;
    else depth_eff = depth_next;
  end
  assign rd_tmp  = depth_eff - 1'b1;
  assign rd_addr = rd_tmp[AW-1:0];
  assign wr_addr = depth[AW-1:0];

  always_ff @(posedge clk) begin
    if (pop && push_en) begin
      stack_mem[wr_addr] <= push_kind;
    end
    if (pop && push_en && wr_addr == rd_addr) top_kind <= push_kind;
    else top_kind <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (pop && head.last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) verdict <= verdict_value;
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for the JSON object structure checker: directed and random texts.
`timescale 1ns / 1ps

// Drives texts into json_object_structure_check one UTF-16 unit per request
// and checks every verdict against a scan predictor kept in step with the
// accepted characters. Directed tests cover each verdict path. A random
// phase mixes well-formed objects, corrupted objects, deep nesting and noise.
// One test holds the verdict side off long enough to back the block up.
module tb;
  import jsc_pkg::*;

  localparam int MAXN        = MAX_NESTING_DEFAULT;
  localparam int RANDOM_UNITS = 900;
  localparam int LONG_HOLD   = 120;
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [15:0] char_code = '0;
  logic        last_char = 1'b0;
  logic        verdict_valid;
  logic        verdict_stall = 1'b0;
  logic [1:0]  verdict;

  json_object_structure_check u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict      (verdict)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Run bookkeeping
  int  error_count     = 0;
  int  texts_sent      = 0;
  int  units_accepted  = 0;
  int  stall_cycles    = 0;
  int  long_holds      = 0;
  int  verdict_tally[3] = '{0, 0, 0};
  bit  tx_no_gaps      = 1'b0;
  bit  rx_no_gaps      = 1'b0;
  bit  hold_off_request = 1'b0;

  verdict_t    verdicts_due[$];
  logic [15:0] text_units[$];

  // Scan predictor state: mirrors the block across accepted characters
  scan_phase_t scan_state = PH_LEAD;
  bit          nest_kinds[MAXN];
  int          nest_level = 0;
  bit          too_deep = 1'b0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // Append one unit to the text being built
  function automatic void append_unit(input logic [15:0] unit);
    text_units.insert(text_units.size(), unit);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic bit is_blank(input logic [15:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_BOM;
  endfunction

  function automatic void open_level(input bit kind);
    // An open past the stack depth ends the scan with the too-deep verdict
    if (nest_level >= MAXN) begin
      too_deep   = 1'b1;
      scan_state = PH_FAIL;
    end else begin
      nest_kinds[nest_level] = kind;
      nest_level++;
      scan_state = PH_BODY;
    end
  endfunction

  function automatic void close_level(input bit kind);
    if (nest_level == 0 || nest_kinds[nest_level - 1] != kind) begin
      scan_state = PH_FAIL;
    end else begin
      nest_level--;
      if (nest_level == 0) scan_state = PH_TAIL;
    end
  endfunction

  // Advance the scan by one accepted unit; on the last unit produce the
  // verdict and return to the leading-skip state for the next text.
  function automatic void scan_unit(input logic [15:0] c, input logic fin,
                                    output bit has, output verdict_t v);
    case (scan_state)
      PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == CHAR_LBRACE) open_level(KIND_BRACE);
          else scan_state = PH_FAIL;
        end
      end
      PH_BODY: begin
        if (c == CHAR_QUOTE) scan_state = PH_STR;
        else if (c == CHAR_LBRACE) open_level(KIND_BRACE);
        else if (c == CHAR_LBRACK) open_level(KIND_BRACK);
        else if (c == CHAR_RBRACE) close_level(KIND_BRACE);
        else if (c == CHAR_RBRACK) close_level(KIND_BRACK);
      end
      PH_STR: begin
        if (c == CHAR_BSLASH) scan_state = PH_ESC;
        else if (c == CHAR_QUOTE) scan_state = PH_BODY;
      end
      PH_ESC: scan_state = PH_STR;
      PH_TAIL: begin
        if (!is_blank(c)) scan_state = PH_FAIL;
      end
      default: scan_state = PH_FAIL;
    endcase
    has = fin;
    v   = VERDICT_MALFORMED;
    if (fin) begin
      if (too_deep) v = VERDICT_TOO_DEEP;
      else if (scan_state == PH_TAIL) v = VERDICT_VALID;
      scan_state = PH_LEAD;
      nest_level = 0;
      too_deep   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: predict on each accepted character, check each accepted verdict
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bit       has;
    verdict_t want;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        units_accepted++;
        scan_unit(char_code, last_char, has, want);
        if (has) verdicts_due.insert(verdicts_due.size(), want);
      end
      if (char_valid && char_stall) stall_cycles++;
      if (verdict_valid && !verdict_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none expected", verdict));
        end else begin
          want = verdicts_due.pop_front();
          verdict_tally[int'(want)]++;
          if (verdict !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Verdict side: random hold before each verdict, or one long hold on request
  // ---------------------------------------------------------------------
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold = LONG_HOLD;
        hold_off_request = 1'b0;
        long_holds++;
      end else begin
        hold = rx_no_gaps ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        verdict_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      verdict_stall <= 1'b0;
      @(posedge clk);
      while (!verdict_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------
  // Offer one unit after a random gap and hold it until accepted. Valid stays
  // high on return so a following unit with no gap goes out back to back.
  task automatic send_unit(input logic [15:0] unit, input bit is_last);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= unit;
    last_char  <= is_last;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  // Send the buffered text, flag its final unit, and clear the buffer
  task automatic send_text();
    foreach (text_units[i]) send_unit(text_units[i], i == text_units.size() - 1);
    texts_sent++;
    text_units.delete();
  endtask

  function automatic void add_ascii(input string s);
    for (int i = 0; i < s.len(); i++) append_unit({8'h00, s[i]});
  endfunction

  task automatic run_ascii(input string s);
    add_ascii(s);
    send_text();
  endtask

  function automatic logic [15:0] pick_blank();
    int k;
    k = $urandom_range(0, 6);
    return (k == 6) ? CHAR_BOM : (k == 5) ? CHAR_SPACE : CHAR_TAB + 16'(k);
  endfunction

  function automatic void add_blanks();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) append_unit(pick_blank());
  endfunction

  // Any unit that is not structural outside a string
  function automatic logic [15:0] pick_plain();
    logic [15:0] c;
    c = 16'($urandom_range(0, 65535));
    if (c == CHAR_LBRACE || c == CHAR_RBRACE || c == CHAR_LBRACK ||
        c == CHAR_RBRACK || c == CHAR_QUOTE) c = 16'h0030;
    return c;
  endfunction

  // String with random content; quotes and backslashes inside are escaped,
  // and escapes also cover arbitrary units
  function automatic void add_string();
    int          n;
    logic [15:0] c;
    append_unit(CHAR_QUOTE);
    n = $urandom_range(0, 5);
    repeat (n) begin
      c = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 5) == 0) begin
        c = ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : c;
        append_unit(CHAR_BSLASH);
      end else if (c == CHAR_QUOTE || c == CHAR_BSLASH) begin
        append_unit(CHAR_BSLASH);
      end else if ($urandom_range(0, 1) == 0) begin
        c = {9'h000, 7'($urandom_range(32, 126))};
        if (c == CHAR_QUOTE || c == CHAR_BSLASH) c = 16'h0061;
      end
      append_unit(c);
    end
    append_unit(CHAR_QUOTE);
  endfunction

  function automatic void add_value(input int lvl);
    int k;
    k = $urandom_range(0, 5);
    if (lvl > 0 && k == 0) add_object(lvl - 1);
    else if (lvl > 0 && k == 1) add_array(lvl - 1);
    else if (k < 4) add_string();
    else repeat ($urandom_range(1, 3)) append_unit(pick_plain());
    add_blanks();
  endfunction

  function automatic void add_object(input int lvl);
    int n;
    append_unit(CHAR_LBRACE);
    add_blanks();
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_ascii(",");
      add_string();
      add_ascii(":");
      add_value(lvl);
    end
    append_unit(CHAR_RBRACE);
  endfunction

  function automatic void add_array(input int lvl);
    int n;
    append_unit(CHAR_LBRACK);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_ascii(",");
      add_value(lvl);
    end
    append_unit(CHAR_RBRACK);
  endfunction

  // Nest to the given depth with random kinds, outermost a brace; close in
  // matching order when balanced, otherwise leave it open
  function automatic void add_deep(input int levels, input bit balanced);
    bit kinds[$];
    bit top;
    for (int i = 0; i < levels; i++) begin
      kinds.insert(kinds.size(), i == 0 ? KIND_BRACE : 1'($urandom_range(0, 1)));
      append_unit(kinds[i] == KIND_BRACE ? CHAR_LBRACE : CHAR_LBRACK);
    end
    if ($urandom_range(0, 1) == 0) add_string();
    if (balanced) begin
      while (kinds.size() > 0) begin
        top = kinds[kinds.size() - 1];
        kinds.delete(kinds.size() - 1);
        append_unit(top == KIND_BRACE ? CHAR_RBRACE : CHAR_RBRACK);
      end
    end
  endfunction

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return CHAR_LBRACE;
      1: return CHAR_RBRACE;
      2: return CHAR_LBRACK;
      3: return CHAR_RBRACK;
      4: return ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : CHAR_BSLASH;
      5: return pick_blank();
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Break a well-formed text in one of several ways
  function automatic void corrupt_text();
    int pos;
    pos = $urandom_range(0, text_units.size() - 1);
    case ($urandom_range(0, 4))
      0: if (pos > 0) text_units = text_units[0:pos - 1];
      1: text_units[pos] = pick_noise();
      2: text_units.push_front(16'h0078);
      3: append_unit(pick_plain());
      default: if (text_units.size() > 1) text_units.delete(pos);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_leading_skip();
    // Every blank kind ahead of the object, a nested object, then a text of blanks only
    for (int c = 9; c <= 13; c++) append_unit(16'(c));
    append_unit(CHAR_SPACE);
    append_unit(CHAR_BOM);
    add_ascii("{}");
    send_text();
    run_ascii("{\"k\":[1,2,{}]}");
    append_unit(CHAR_SPACE);
    append_unit(CHAR_BOM);
    append_unit(CHAR_TAB);
    send_text();
  endtask

  task automatic test_bad_first_unit();
    run_ascii("[]");
    run_ascii("}");
    // Units just outside the blank range
    append_unit(16'h0008);
    add_ascii("{}");
    send_text();
    append_unit(16'h000E);
    add_ascii("{}");
    send_text();
  endtask

  task automatic test_close_mismatch();
    run_ascii("{]");
    run_ascii("{[}]");
    run_ascii("{\"a\":1}}");
  endtask

  task automatic test_string_skipping();
    // Structural units, an escaped quote and an escaped backslash in strings
    run_ascii("{\"}]{[\\\"\\\\\":\"x\"}");
    add_ascii("{\"");
    append_unit(16'hFFFF);
    append_unit(CHAR_BSLASH);
    append_unit(16'hFFFF);
    add_ascii("\"}");
    send_text();
  endtask

  task automatic test_unfinished();
    run_ascii("{");
    run_ascii("{[");
    run_ascii("{\"ab");
    run_ascii("{\"\\");
  endtask

  task automatic test_trailing();
    add_ascii("{} \r");
    append_unit(CHAR_BOM);
    send_text();
    run_ascii("{} x");
    run_ascii("{}{}");
  endtask

  task automatic test_nesting_limit();
    // Exactly full stack, one past it, and errors on both sides of overflow
    add_deep(MAXN, 1'b1);
    send_text();
    add_deep(MAXN + 1, 1'b1);
    send_text();
    add_deep(MAXN + 1, 1'b0);
    add_ascii("]]x");
    send_text();
    add_ascii("{]");
    repeat (MAXN + 4) append_unit(CHAR_LBRACE);
    send_text();
  endtask

  task automatic test_field_extremes();
    append_unit(CHAR_LBRACE);
    append_unit(16'h0000);
    append_unit(16'hFFFF);
    append_unit(CHAR_RBRACE);
    send_text();
    add_ascii("{}");
    append_unit(16'hFFFF);
    send_text();
    add_ascii("{}");
    append_unit(16'h0000);
    send_text();
  endtask

  // Hold the verdict side off while short texts stream in without gaps, so
  // the request queue fills and the block stalls its character input
  task automatic test_backpressure();
    tx_no_gaps = 1'b1;
    hold_off_request = 1'b1;
    repeat (30) run_ascii("{}");
    tx_no_gaps = 1'b0;
  endtask

  task automatic test_random_texts();
    int sent_here;
    int pick;
    sent_here = 0;
    while (sent_here < RANDOM_UNITS) begin
      // Occasional stretches with no idling on either side
      tx_no_gaps = ($urandom_range(0, 3) == 0);
      rx_no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        add_blanks();
        add_object(3);
        add_blanks();
        if (pick >= 60) corrupt_text();
      end else if (pick < 86) begin
        add_deep($urandom_range(MAXN - 4, MAXN + 4), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 12)) append_unit(pick_noise());
      end
      sent_here += text_units.size();
      send_text();
    end
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_leading_skip();
    test_bad_first_unit();
    test_close_mismatch();
    test_string_skipping();
    test_unfinished();
    test_trailing();
    test_nesting_limit();
    test_field_extremes();
    test_backpressure();
    test_random_texts();

    // Drop valid, then wait out the outstanding verdicts and the pipeline
    char_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && verdicts_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));

    $display("Covered %0d texts in %0d characters; valid/malformed/too deep: %0d/%0d/%0d",
             texts_sent, units_accepted, verdict_tally[0], verdict_tally[1],
             verdict_tally[2]);
    $display("Character input stalled %0d cycles; %0d long verdict hold(s)",
             stall_cycles, long_holds);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: json_object_structure_check.f
sv/jsc_pkg.sv
sv/jsc_front.sv
sv/jsc_queue.sv
sv/jsc_back.sv
sv/json_object_structure_check.sv
sim/tb.sv
